### rtl/bfle_pkg.sv
// Package for the byte FIFO with line extraction: sizes, codes, result types
// and small pointer helpers. Depends on nothing; every other file but bfle_ram imports it.
package bfle_pkg;

	localparam int DEPTH    = 4096;
	localparam int PTR_W    = $clog2(DEPTH);
	localparam int CNT_W    = 12;
	localparam int DATA_W   = 8;
	localparam int LIM_W    = 7;
	localparam int LINE_MAX = 64;

	localparam logic [DATA_W-1:0] CH_CR = 8'h0D;
	localparam logic [DATA_W-1:0] CH_LF = 8'h0A;

	typedef enum logic [2:0] {
		OP_PUT   = 3'd0,
		OP_GET   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_FLUSH = 3'd3,
		OP_LINE  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_REFUSED = 2'd1,
		STS_NO_LINE = 2'd2,
		STS_PURGED  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD_DATA,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SKIP_RD,
		ST_SKIP_CHK,
		ST_LINE_RD,
		ST_LINE_OUT
	} state_t;

	typedef struct packed {
		logic [DATA_W-1:0] data;
		status_t           status;
		logic              last;
		logic [CNT_W-1:0]  used;
		logic [CNT_W-1:0]  free;
	} result_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} emit_t;

	typedef struct packed {
		logic              we;
		logic [PTR_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [PTR_W-1:0]  raddr;
	} ram_req_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Adds an offset that is known to be below DEPTH, wrapping once.
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
			input logic [LIM_W-1:0] n);
		logic [PTR_W:0] sum;
		sum = {1'b0, p} + (PTR_W+1)'(n);
		if (sum >= (PTR_W+1)'(DEPTH)) begin
			sum = sum - (PTR_W+1)'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	function automatic logic [PTR_W:0] used_of(input logic [PTR_W-1:0] wp,
			input logic [PTR_W-1:0] rp);
		if (wp >= rp) begin
			return {1'b0, wp} - {1'b0, rp};
		end
		return ({1'b0, wp} + (PTR_W+1)'(DEPTH)) - {1'b0, rp};
	endfunction

	function automatic logic is_term(input logic [DATA_W-1:0] b);
		return (b == CH_CR) || (b == CH_LF);
	endfunction

endpackage

### rtl/bfle_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Self-contained; used for the byte store.
module bfle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/bfle_outreg.sv
// Result holding register between the sequencer and the output stream.
// Depends on bfle_pkg for the result types.
module bfle_outreg import bfle_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  emit_t   emit,
	input  logic    out_ready,
	output logic    slot_free,
	output logic    out_valid,
	output result_t out_res
);

	logic    valid_q;
	result_t res_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit.valid) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			res_q <= emit.res;
		end
	end

endmodule

### rtl/bfle_ctrl.sv
// Sequencer of the byte FIFO: pointers, line limit register and the
// read-check-advance walk over the byte store. Depends on bfle_pkg.
module bfle_ctrl import bfle_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        in_op,
	input  logic [DATA_W-1:0] in_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LIM_W-1:0]  cfg_data,
	input  logic              slot_free,
	output emit_t             emit,
	output ram_req_t          ram_req,
	input  logic [DATA_W-1:0] ram_rdata
);

	state_t            state_q, state_d;
	op_t               op_q, op_d;
	logic [DATA_W-1:0] din_q, din_d;
	logic [PTR_W-1:0]  wp_q, wp_d, rp_q, rp_d, sp_q, sp_d;
	logic [LIM_W-1:0]  j_q, j_d, len_q, len_d, idx_q, idx_d;
	logic [LIM_W-1:0]  line_limit_q, lim;
	logic [PTR_W:0]    used_q, used_nx;

	assign cfg_ready = 1'b1;
	assign lim       = (line_limit_q > LIM_W'(LINE_MAX)) ? LIM_W'(LINE_MAX) : line_limit_q;
	assign used_q    = used_of(wp_q, rp_q);
	assign used_nx   = used_of(wp_d, rp_d);

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		din_d   = din_q;
		wp_d    = wp_q;
		rp_d    = rp_q;
		sp_d    = sp_q;
		j_d     = j_q;
		len_d   = len_q;
		idx_d   = idx_q;
		in_ready = 1'b0;
		ram_req = '0;
		emit.valid      = 1'b0;
		emit.res.data   = '0;
		emit.res.status = STS_OK;
		emit.res.last   = 1'b1;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d    = op_t'(in_op);
					din_d   = in_data;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (op_q)
					OP_PUT: begin
						if (slot_free) begin
							emit.valid = 1'b1;
							if (used_q >= (PTR_W+1)'(DEPTH - 1)) begin
								emit.res.status = STS_REFUSED;
							end else begin
								ram_req.we    = 1'b1;
								ram_req.waddr = wp_q;
								ram_req.wdata = din_q;
								wp_d          = ptr_inc(wp_q);
								emit.res.data = din_q;
							end
							state_d = ST_IDLE;
						end
					end
					OP_GET, OP_PEEK: begin
						if (used_q == '0) begin
							if (slot_free) begin
								emit.valid      = 1'b1;
								emit.res.status = STS_REFUSED;
								state_d         = ST_IDLE;
							end
						end else begin
							ram_req.re    = 1'b1;
							ram_req.raddr = rp_q;
							state_d       = ST_RD_DATA;
						end
					end
					OP_FLUSH: begin
						if (slot_free) begin
							emit.valid = 1'b1;
							wp_d       = rp_q;
							state_d    = ST_IDLE;
						end
					end
					OP_LINE: begin
						if (used_q == '0) begin
							if (slot_free) begin
								emit.valid      = 1'b1;
								emit.res.status = STS_NO_LINE;
								state_d         = ST_IDLE;
							end
						end else begin
							// The oldest byte always belongs to the line.
							j_d     = LIM_W'(1);
							sp_d    = ptr_inc(rp_q);
							state_d = ST_SCAN_RD;
						end
					end
					default: begin
						if (slot_free) begin
							emit.valid      = 1'b1;
							emit.res.status = STS_REFUSED;
							state_d         = ST_IDLE;
						end
					end
				endcase
			end
			ST_RD_DATA: begin
				if (slot_free) begin
					emit.valid    = 1'b1;
					emit.res.data = ram_rdata;
					if (op_q == OP_GET) begin
						rp_d = ptr_inc(rp_q);
					end
					state_d = ST_IDLE;
				end
			end
			ST_SCAN_RD: begin
				if (j_q >= lim) begin
					// Overlong line: drop the oldest byte only.
					if (slot_free) begin
						emit.valid      = 1'b1;
						emit.res.status = STS_PURGED;
						rp_d            = ptr_inc(rp_q);
						state_d         = ST_IDLE;
					end
				end else if ((PTR_W+1)'(j_q) >= used_q) begin
					if (slot_free) begin
						emit.valid      = 1'b1;
						emit.res.status = STS_NO_LINE;
						state_d         = ST_IDLE;
					end
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = sp_q;
					state_d       = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				if (is_term(ram_rdata)) begin
					len_d   = j_q;
					idx_d   = '0;
					sp_d    = rp_q;
					rp_d    = ptr_add(rp_q, j_q);
					state_d = ST_SKIP_RD;
				end else begin
					j_d     = j_q + 1'b1;
					sp_d    = ptr_inc(sp_q);
					state_d = ST_SCAN_RD;
				end
			end
			ST_SKIP_RD: begin
				if (rp_q == wp_q) begin
					state_d = ST_LINE_RD;
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = rp_q;
					state_d       = ST_SKIP_CHK;
				end
			end
			ST_SKIP_CHK: begin
				if (is_term(ram_rdata)) begin
					rp_d    = ptr_inc(rp_q);
					state_d = ST_SKIP_RD;
				end else begin
					state_d = ST_LINE_RD;
				end
			end
			ST_LINE_RD: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = sp_q;
				state_d       = ST_LINE_OUT;
			end
			ST_LINE_OUT: begin
				if (slot_free) begin
					emit.valid    = 1'b1;
					emit.res.data = ram_rdata;
					emit.res.last = (idx_q + 1'b1) == len_q;
					sp_d          = ptr_inc(sp_q);
					idx_d         = idx_q + 1'b1;
					state_d       = emit.res.last ? ST_IDLE : ST_LINE_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		emit.res.used = CNT_W'(used_nx);
		emit.res.free = CNT_W'((PTR_W+1)'(DEPTH - 1) - used_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_PUT;
			wp_q         <= '0;
			rp_q         <= '0;
			sp_q         <= '0;
			j_q          <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			line_limit_q <= LIM_W'(LINE_MAX);
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			wp_q    <= wp_d;
			rp_q    <= rp_d;
			sp_q    <= sp_d;
			j_q     <= j_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			if (cfg_valid && cfg_ready) begin
				line_limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		din_q <= din_d;
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> slot_free) else $error("result produced while output busy");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= (PTR_W+1)'(DEPTH - 1)) else $error("fill level beyond capacity");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN_CHK |-> (j_q != '0) && (j_q < LIM_W'(LINE_MAX)))
		else $error("scan length out of range");

	a_line_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LINE_OUT |-> idx_q < len_q) else $error("line index past end");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_EXEC) else $error("request not started");

endmodule

### rtl/byte_fifo_with_line_extract_top.sv
// Top level of the byte FIFO with line extraction: stream ports, byte store
// RAM, sequencer and result register. Depends on bfle_pkg and all bfle_ modules.
//
// Usage: each request on the s_axis channel carries an operation in tuser and a
// byte in tdata. Put, get, peek and flush give one result; line extract gives
// one result per line byte (tlast on the final one) or a single status result.
// Results leave on m_axis with the byte, the used and free counts in tdata and
// the status in tuser. The line limit must be written through cfg_valid/cfg_data
// while the block is idle; the block does not enforce it. cfg_ready is always high.
// Sequence: a request is accepted, then executed in the next cycle. Put and
// flush give their result from the execute state, get and peek from the
// read-data state after it, because the byte store read is registered. A
// new request is taken once the previous one has produced its last result.
// Line extract scans bytes, skips trailing CR/LF and delivers line bytes,
// each step being one store read state followed by one check or output state.
// Reset empties the FIFO and sets the line limit to 64; store contents are left
// as they are. When the receiver stalls, the result is held in the output
// register and the sequencer waits until that register can take the next one.
module byte_fifo_with_line_extract_top import bfle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
	input  logic [2:0]  s_axis_tuser,   // [2:0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] data_out, [19:8] used_count, [31:20] free_count
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data        // line_limit
);

	emit_t             emit;
	ram_req_t          ram_req;
	logic [DATA_W-1:0] ram_rdata;
	logic              slot_free;
	result_t           out_res;

	bfle_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	bfle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.slot_free (slot_free),
		.emit      (emit),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	bfle_outreg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.out_ready (m_axis_tready),
		.slot_free (slot_free),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {out_res.free, out_res.used, out_res.data};
	assign m_axis_tuser = out_res.status;
	assign m_axis_tlast = out_res.last;

endmodule

### sim/bfle_checker.sv
// Checker for the byte FIFO with line extraction: follows every accepted request
// and line limit write, predicts the results and compares them with the output stream.
// Depends on bfle_pkg for sizes, operation and status codes and the result layout.
module bfle_checker import bfle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic [2:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	output int          fail_count,
	output int          pending,
	output int          checked
);

	logic [7:0] model_mem [DEPTH];
	int         head_ptr = 0;
	int         tail_ptr = 0;
	int         limit_reg = LINE_MAX;
	result_t    expected_q [$];
	int         errs = 0;
	int         seen = 0;

	function automatic int bytes_held();
		return (head_ptr - tail_ptr + DEPTH) % DEPTH;
	endfunction

	function automatic bit is_eol(input logic [7:0] b);
		return (b == CH_CR) || (b == CH_LF);
	endfunction

	// Counts are taken from the model state at the moment the result is queued.
	function automatic void expect_result(input logic [7:0] b, input status_t st,
			input bit fin);
		result_t r;
		r.data   = b;
		r.status = st;
		r.last   = fin;
		r.used   = CNT_W'(bytes_held());
		r.free   = CNT_W'(DEPTH - 1 - bytes_held());
		expected_q.push_back(r);
	endfunction

	function automatic void predict_request(input logic [2:0] op, input logic [7:0] b);
		int         held;
		int         lim;
		int         n;
		int         p;
		int         rest;
		logic [7:0] rd_byte;
		logic [7:0] line_bytes [$];
		held = bytes_held();
		case (op)
			OP_PUT: begin
				if (held >= DEPTH - 1) begin
					expect_result('0, STS_REFUSED, 1'b1);
				end else begin
					model_mem[head_ptr] = b;
					head_ptr = (head_ptr + 1) % DEPTH;
					expect_result(b, STS_OK, 1'b1);
				end
			end
			OP_GET, OP_PEEK: begin
				if (held == 0) begin
					expect_result('0, STS_REFUSED, 1'b1);
				end else begin
					rd_byte = model_mem[tail_ptr];
					if (op == OP_GET) begin
						tail_ptr = (tail_ptr + 1) % DEPTH;
					end
					expect_result(rd_byte, STS_OK, 1'b1);
				end
			end
			OP_FLUSH: begin
				head_ptr = tail_ptr;
				expect_result('0, STS_OK, 1'b1);
			end
			OP_LINE: begin
				lim = (limit_reg > LINE_MAX) ? LINE_MAX : limit_reg;
				if (held == 0) begin
					expect_result('0, STS_NO_LINE, 1'b1);
				end else begin
					// The oldest byte always belongs to the line, so the scan starts one past it.
					n = 1;
					p = (tail_ptr + 1) % DEPTH;
					while (n < held && n < lim && !is_eol(model_mem[p])) begin
						n++;
						p = (p + 1) % DEPTH;
					end
					if (n >= lim) begin
						tail_ptr = (tail_ptr + 1) % DEPTH;
						expect_result('0, STS_PURGED, 1'b1);
					end else if (n >= held) begin
						expect_result('0, STS_NO_LINE, 1'b1);
					end else begin
						repeat (n) begin
							line_bytes.push_back(model_mem[tail_ptr]);
							tail_ptr = (tail_ptr + 1) % DEPTH;
						end
						// Terminators after the line are dropped before any result leaves,
						// so every line result already shows the final counts.
						rest = held - n;
						while (rest != 0 && is_eol(model_mem[tail_ptr])) begin
							rest--;
							tail_ptr = (tail_ptr + 1) % DEPTH;
						end
						foreach (line_bytes[i]) begin
							expect_result(line_bytes[i], STS_OK, i == n - 1);
						end
					end
				end
			end
			default: begin
				expect_result('0, STS_REFUSED, 1'b1);
			end
		endcase
	endfunction

	// Only the first mismatches are printed to keep the log readable.
	function automatic void compare_field(input string what, input int want, input int got);
		if (want != got) begin
			errs++;
			if (errs <= 50) begin
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		if (!arst_n) begin
			head_ptr  = 0;
			tail_ptr  = 0;
			limit_reg = LINE_MAX;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_reg = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				seen++;
				if (expected_q.size() == 0) begin
					errs++;
					$display("%0t: unexpected result, expected none, got tdata 0x%0h status %0d",
						$time, m_axis_tdata, m_axis_tuser);
				end else begin
					want = expected_q.pop_front();
					compare_field("data", want.data, m_axis_tdata[7:0]);
					compare_field("used", want.used, m_axis_tdata[19:8]);
					compare_field("free", want.free, m_axis_tdata[31:20]);
					compare_field("status", want.status, m_axis_tuser);
					compare_field("last", want.last, m_axis_tlast);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_request(s_axis_tuser, s_axis_tdata);
			end
		end
		fail_count <= errs;
		pending    <= expected_q.size();
		checked    <= seen;
	end

endmodule

### sim/tb.sv
// Testbench top for the byte FIFO with line extraction: clock, reset, request and
// line limit stimulus, receiver stalls, watchdog and verdict. Depends on bfle_pkg,
// bfle_checker and byte_fifo_with_line_extract_top.
module tb;
	import bfle_pkg::*;

	localparam logic [2:0] OP_SPARE_LO = 3'(OP_LINE) + 3'd1;
	localparam logic [2:0] OP_SPARE_HI = '1;
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 400;
	localparam int SETTLE      = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = OP_PUT;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	int   tx_idle_pct = 21;
	int   rx_idle_pct = 68;
	int   req_count = 0;
	int   line_reqs = 0;
	int   limit_writes = 0;
	int   limit_now = LINE_MAX;
	logic hold_go = 1'b0;
	int   quiet_cycles = 0;
	int   fail_count;
	int   pending;
	int   checked;

	byte_fifo_with_line_extract_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	bfle_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off each time hold_go toggles.
	initial begin : receiver
		int   hold_left;
		logic hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go != hold_seen) begin
				hold_seen = hold_go;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_req(input logic [2:0] op, input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		req_count++;
		if (op == OP_LINE) begin
			line_reqs++;
		end
	endtask

	// Holds back further requests until every expected result has been checked.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(input logic [6:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = v;
		limit_writes++;
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_LF);
		return b;
	endfunction

	task automatic put_line(input int len, input int n_eol);
		repeat (len) send_req(OP_PUT, text_byte());
		repeat (n_eol) send_req(OP_PUT, $urandom_range(1) ? CH_CR : CH_LF);
	endtask

	// Mostly whole lines followed by extracts; the rest is reads, lone extracts,
	// stray bytes, flushes and unused operation codes.
	task automatic random_burst();
		int pick;
		int eff;
		int len;
		pick = $urandom_range(99);
		eff = (limit_now > LINE_MAX) ? LINE_MAX : limit_now;
		if (pick < 55) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				len = eff - 1;
			end else if (pick < 20) begin
				len = eff + $urandom_range(8);
			end else begin
				len = $urandom_range(1, 10);
			end
			if (len < 1) begin
				len = 1;
			end
			put_line(len, $urandom_range(1, 3));
			repeat ($urandom_range(1, 2)) send_req(OP_LINE, 8'($urandom_range(255)));
		end else if (pick < 70) begin
			repeat ($urandom_range(1, 4)) begin
				send_req($urandom_range(1) ? OP_GET : OP_PEEK, 8'($urandom_range(255)));
			end
		end else if (pick < 80) begin
			send_req(OP_LINE, 8'($urandom_range(255)));
		end else if (pick < 90) begin
			repeat ($urandom_range(1, 3)) send_req(OP_PUT, 8'($urandom_range(255)));
		end else if (pick < 95) begin
			send_req(OP_FLUSH, 8'($urandom_range(255)));
		end else begin
			send_req(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), 8'($urandom_range(255)));
		end
	endtask

	task automatic run_random(input int n);
		int target;
		target = req_count + n;
		while (req_count < target) begin
			random_burst();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty store: reads are refused and extract finds no line; spare codes are refused too.
		send_req(OP_GET, 8'hA5);
		send_req(OP_PEEK, 8'h5A);
		send_req(OP_LINE, 8'hFF);
		send_req(OP_SPARE_LO, 8'h00);
		send_req(OP_SPARE_HI, 8'hFF);
		send_req(OP_FLUSH, 8'h00);
		send_req(OP_PUT, 8'h00);
		send_req(OP_PUT, 8'hFF);
		send_req(OP_PEEK, 8'h00);
		send_req(OP_GET, 8'h00);
		send_req(OP_GET, 8'h00);
		// A CR at the head forms a line on its own, and the LF after it is skipped.
		send_req(OP_PUT, CH_CR);
		send_req(OP_PUT, CH_LF);
		send_req(OP_PUT, 8'h41);
		send_req(OP_LINE, 8'h00);
		send_req(OP_LINE, 8'h00);
		send_req(OP_PUT, CH_LF);
		send_req(OP_LINE, 8'h00);
		send_req(OP_PUT, 8'h42);
		send_req(OP_FLUSH, 8'h00);

		write_limit(7'd2);
		send_req(OP_PUT, 8'h78);
		send_req(OP_PUT, 8'h79);
		send_req(OP_PUT, 8'h7A);
		send_req(OP_LINE, 8'h00);
		run_random(50);

		write_limit(7'd127);
		run_random(25);
		drain_results();
		run_random(25);

		tx_idle_pct = 68;
		rx_idle_pct = 21;
		write_limit(7'($urandom_range(3, 63)));
		hold_go <= ~hold_go;
		run_random(55);
		write_limit(7'd1);
		run_random(45);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_limit(7'd0);
		run_random(40);
		write_limit(7'd64);
		run_random(60);

		drain_results();
		repeat (SETTLE) @(posedge clk);
		$display("Checked %0d results from %0d requests, %0d of them line extracts,",
			checked, req_count, line_reqs);
		$display("over %0d line limit settings and a long output stall.",
			limit_writes + 1);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
